FILE: sv/rbe_pkg.sv
`default_nettype none
package rbe_pkg;

	localparam int ENTRIES = 1024;
	localparam int IDX_W   = 10;
	localparam int CNT_W   = 11;
	localparam int SUM_W   = 27;
	localparam int TGT_W   = 35;
	localparam int WIDE_W  = 64;
	localparam int BYTES_W = 34;
	localparam int CTR_W   = 32;
	localparam int ST_W    = 2;

	localparam logic [SUM_W-1:0]  BUDGET      = SUM_W'(67108864);
	localparam logic [WIDE_W-1:0] BUDGET_WIDE = WIDE_W'(67108864);

	localparam logic [1:0] REG_TARGET = 2'd0;
	localparam logic [1:0] REG_COUNT  = 2'd1;
	localparam logic [1:0] REG_FLOW   = 2'd2;

	typedef enum logic [ST_W-1:0] {
		ES_UNLOADED = 2'd0,
		ES_READY    = 2'd1,
		ES_FAILED   = 2'd2
	} entry_state_t;

	typedef enum logic [2:0] {
		STS_STORED  = 3'd0,
		STS_OUTSIDE = 3'd1,
		STS_FAILED  = 3'd2,
		STS_NO_ROOM = 3'd3,
		STS_SWEEP   = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_VIS,
		S_SLOTS,
		S_LA,
		S_BND,
		S_MOD,
		S_DEC,
		S_SCAN,
		S_FIN,
		S_PUSH
	} fsm_t;

	typedef struct packed {
		logic              start;
		logic [WIDE_W-1:0] dividend;
		logic [TGT_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic [WIDE_W-1:0] quotient;
		logic [TGT_W-1:0]  remainder;
	} div_rsp_t;

endpackage
`default_nettype wire

FILE: sv/resident_budget_evictor.sv
`default_nettype none
// Keeps a residency state and a byte size per entry under a fixed byte budget and reports one
// result per transfer. After reset the state memory is cleared entry by entry, during which
// in_stall stays high. An item then passes through these steps: working out the window, a
// division for the lookahead when the target register is nonzero, another division for the
// window start in carousel flow when the window does not cover all entries, and one entry per
// cycle through the state and size memories for each scan (two for an accept whose entry lies
// in the window and has not failed, one for a sweep). The next item is taken once the
// result has entered the output register.
module resident_budget_evictor import rbe_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [TGT_W-1:0]   cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               mode,
	input  wire logic [IDX_W-1:0]   thumb_index,
	input  wire logic [15:0]        pix_width,
	input  wire logic [15:0]        pix_height,
	input  wire logic               from_cache,
	input  wire logic [CNT_W-1:0]   range_first,
	input  wire logic [CNT_W-1:0]   range_end,
	input  wire logic [CNT_W-1:0]   range_wrap_end,
	input  wire logic [CNT_W-1:0]   selected_entry,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              status,
	output logic [CNT_W-1:0]        evicted_now,
	output logic [SUM_W-1:0]        resident_total,
	output logic [SUM_W-1:0]        resident_peak,
	output logic [CTR_W-1:0]        hit_total,
	output logic [CTR_W-1:0]        decoded_total,
	output logic [CTR_W-1:0]        discarded_total,
	output logic [CTR_W-1:0]        failed_total,
	output logic [CTR_W-1:0]        evicted_total
);

	fsm_t st_q, st_d;

	logic [TGT_W-1:0] tgt_q;
	logic [CNT_W-1:0] cnt_q;
	logic             wrap_q;
	logic [CNT_W-1:0] n_act;

	logic             mode_q, cache_q;
	logic [IDX_W-1:0] idx_q;
	logic [15:0]      w_q, h_q;
	logic [CNT_W-1:0] first_q, end_q, wend_q, sel_q;

	logic [WIDE_W-1:0] vis_q, la_q, low_q, high_q, span_q;
	logic              all_q;
	logic [IDX_W-1:0]  start_q;
	logic [BYTES_W-1:0] bytes_q;

	logic [WIDE_W-1:0] vis_d, la_d, half_d, low_d, rem_d, high_d, span_d, modarg_d;
	logic              all_d, need_mod;

	logic [IDX_W-1:0] clr_q;
	logic [CNT_W-1:0] scan_i_q;
	logic             pass_q;
	logic             valid_s1;
	logic [IDX_W-1:0] addr_s1;

	logic [SUM_W-1:0] sum_q, peak_q, room, sum_new;
	logic [CTR_W-1:0] hit_q, dec_q, disc_q, fail_q, evc_q;
	logic [CNT_W-1:0] evnow_q;
	status_t          status_q;

	logic             out_valid_q;
	logic             accept_in, push, no_fit, fail_item, win_idx, issue, scan_done, evict;
	logic [31:0]      prod;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic              st_we, sz_we;
	logic [IDX_W-1:0]  st_waddr;
	entry_state_t      st_wdata;
	logic [ST_W-1:0]   st_rdata;
	logic [SUM_W-1:0]  sz_rdata;
	entry_state_t      st_rd;

	function automatic logic in_vis(input logic [CNT_W-1:0] a);
		return ((a >= first_q) && (a < end_q)) || (a < wend_q);
	endfunction

	function automatic logic in_win(input logic [CNT_W-1:0] i);
		logic [CNT_W:0] off;
		logic           r;
		off = (CNT_W+1)'(i) + (CNT_W+1)'(n_act) - (CNT_W+1)'(start_q);
		if (off >= (CNT_W+1)'(n_act)) begin
			off = off - (CNT_W+1)'(n_act);
		end
		if ((vis_q == '0) || (i >= n_act)) begin
			r = 1'b0;
		end else if (!wrap_q) begin
			r = (WIDE_W'(i) >= low_q) && (WIDE_W'(i) < high_q);
		end else if (all_q) begin
			r = 1'b1;
		end else begin
			r = WIDE_W'(off) < span_q;
		end
		return r;
	endfunction

	assign n_act = (cnt_q > CNT_W'(ENTRIES)) ? CNT_W'(ENTRIES) : cnt_q;

	assign vis_d  = WIDE_W'(end_q) - WIDE_W'(first_q) + WIDE_W'(wend_q);
	assign half_d = (div_rsp.quotient - vis_q) >> 1;

	always_comb begin
		if (tgt_q == '0) begin
			la_d = vis_q;
		end else if (div_rsp.quotient <= vis_q) begin
			la_d = '0;
		end else begin
			la_d = (half_d < vis_q) ? half_d : vis_q;
		end
	end

	assign low_d    = (WIDE_W'(first_q) > la_q) ? WIDE_W'(first_q) - la_q : '0;
	assign rem_d    = WIDE_W'(n_act) - WIDE_W'(end_q);
	assign high_d   = WIDE_W'(end_q) + ((la_q < rem_d) ? la_q : rem_d);
	assign span_d   = vis_q + {la_q[WIDE_W-2:0], 1'b0};
	assign all_d    = span_d >= WIDE_W'(n_act);
	assign modarg_d = WIDE_W'(first_q) + WIDE_W'(n_act) - la_q;
	assign need_mod = wrap_q && !all_d && (n_act != '0);

	assign prod      = w_q * h_q;
	assign room      = (sum_q >= BUDGET) ? '0 : BUDGET - sum_q;
	assign no_fit    = bytes_q > BYTES_W'(room);
	assign fail_item = (w_q == '0) || (h_q == '0) || (bytes_q > BYTES_W'(BUDGET));
	assign issue     = scan_i_q < n_act;
	assign scan_done = (scan_i_q == n_act) && !valid_s1;
	assign st_rd     = entry_state_t'(st_rdata);
	assign sum_new   = sum_q + SUM_W'(bytes_q);

	always_comb begin
		win_idx = in_win({1'b0, idx_q});
	end

	assign accept_in = in_valid && (st_q == S_IDLE);
	assign push      = (st_q == S_PUSH) && (!out_valid_q || !out_stall);
	assign in_stall  = st_q != S_IDLE;

	always_comb begin
		evict = 1'b0;
		if ((st_q == S_SCAN) && valid_s1 && (st_rd == ES_READY)) begin
			if (mode_q) begin
				evict = !in_win({1'b0, addr_s1});
			end else begin
				evict = (addr_s1 != idx_q) && ({1'b0, addr_s1} != sel_q) &&
					(in_vis({1'b0, addr_s1}) == pass_q) && no_fit;
			end
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			S_CLEAR: if (clr_q == '1) st_d = S_IDLE;
			S_IDLE:  if (in_valid) st_d = S_VIS;
			S_VIS:   st_d = (tgt_q != '0) ? S_SLOTS : S_LA;
			S_SLOTS: if (!div_rsp.busy) st_d = S_LA;
			S_LA:    st_d = S_BND;
			S_BND: begin
				if (need_mod) st_d = S_MOD;
				else st_d = mode_q ? S_SCAN : S_DEC;
			end
			S_MOD:   if (!div_rsp.busy) st_d = mode_q ? S_SCAN : S_DEC;
			S_DEC:   st_d = (win_idx && !fail_item) ? S_SCAN : S_PUSH;
			S_SCAN:  if (scan_done && (mode_q || pass_q)) st_d = S_FIN;
			S_FIN:   st_d = S_PUSH;
			S_PUSH:  if (!out_valid_q || !out_stall) st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = BUDGET_WIDE;
		div_req.divisor  = tgt_q;
		st_we    = 1'b0;
		st_waddr = idx_q;
		st_wdata = ES_UNLOADED;
		sz_we    = 1'b0;
		unique case (st_q)
			S_CLEAR: begin
				st_we    = 1'b1;
				st_waddr = clr_q;
			end
			S_VIS: div_req.start = tgt_q != '0;
			S_BND: begin
				div_req.start    = need_mod;
				div_req.dividend = modarg_d;
				div_req.divisor  = TGT_W'(n_act);
			end
			S_DEC: begin
				if (!win_idx) begin
					st_we = 1'b1;
				end else if (fail_item) begin
					st_we    = 1'b1;
					st_wdata = ES_FAILED;
				end
			end
			S_SCAN: begin
				st_we    = evict;
				st_waddr = addr_s1;
			end
			S_FIN: begin
				st_we    = !mode_q;
				st_wdata = no_fit ? ES_UNLOADED : ES_READY;
				sz_we    = !mode_q && !no_fit;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_CLEAR;
			tgt_q       <= '0;
			cnt_q       <= '0;
			wrap_q      <= 1'b0;
			clr_q       <= '0;
			scan_i_q    <= '0;
			pass_q      <= 1'b0;
			valid_s1    <= 1'b0;
			sum_q       <= '0;
			peak_q      <= '0;
			hit_q       <= '0;
			dec_q       <= '0;
			disc_q      <= '0;
			fail_q      <= '0;
			evc_q       <= '0;
			evnow_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_write) begin
				unique case (cfg_index)
					REG_TARGET: tgt_q  <= cfg_data;
					REG_COUNT:  cnt_q  <= cfg_data[CNT_W-1:0];
					REG_FLOW:   wrap_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (st_q == S_CLEAR) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (accept_in) begin
				scan_i_q <= '0;
				pass_q   <= 1'b0;
				evnow_q  <= '0;
			end
			if (st_q == S_SCAN) begin
				valid_s1 <= issue;
				if (issue) begin
					scan_i_q <= scan_i_q + CNT_W'(1);
				end else if (scan_done && !mode_q && !pass_q) begin
					pass_q   <= 1'b1;
					scan_i_q <= '0;
				end
			end else begin
				valid_s1 <= 1'b0;
			end
			if (evict) begin
				sum_q   <= (sz_rdata <= sum_q) ? sum_q - sz_rdata : '0;
				evc_q   <= evc_q + CTR_W'(1);
				evnow_q <= evnow_q + CNT_W'(1);
			end
			if (st_q == S_DEC) begin
				if (!win_idx) begin
					disc_q <= disc_q + CTR_W'(1);
				end else if (fail_item) begin
					fail_q <= fail_q + CTR_W'(1);
				end
			end
			if ((st_q == S_FIN) && !mode_q) begin
				if (no_fit) begin
					disc_q <= disc_q + CTR_W'(1);
				end else begin
					sum_q <= sum_new;
					if (sum_new > peak_q) begin
						peak_q <= sum_new;
					end
					if (cache_q) begin
						hit_q <= hit_q + CTR_W'(1);
					end else begin
						dec_q <= dec_q + CTR_W'(1);
					end
				end
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			mode_q  <= mode;
			idx_q   <= thumb_index;
			w_q     <= pix_width;
			h_q     <= pix_height;
			cache_q <= from_cache;
			first_q <= range_first;
			end_q   <= range_end;
			wend_q  <= range_wrap_end;
			sel_q   <= selected_entry;
		end
		if (st_q == S_VIS) begin
			vis_q   <= vis_d;
			bytes_q <= {prod, 2'b00};
		end
		if (st_q == S_LA) begin
			la_q <= la_d;
		end
		if (st_q == S_BND) begin
			low_q  <= low_d;
			high_q <= high_d;
			span_q <= span_d;
			all_q  <= all_d;
		end
		if ((st_q == S_MOD) && !div_rsp.busy) begin
			start_q <= div_rsp.remainder[IDX_W-1:0];
		end
		if (st_q == S_SCAN) begin
			addr_s1 <= scan_i_q[IDX_W-1:0];
		end
		if (st_q == S_DEC) begin
			status_q <= win_idx ? STS_FAILED : STS_OUTSIDE;
		end
		if (st_q == S_FIN) begin
			if (mode_q) status_q <= STS_SWEEP;
			else status_q <= no_fit ? STS_NO_ROOM : STS_STORED;
		end
		if (push) begin
			status          <= status_q;
			evicted_now     <= evnow_q;
			resident_total  <= sum_q;
			resident_peak   <= peak_q;
			hit_total       <= hit_q;
			decoded_total   <= dec_q;
			discarded_total <= disc_q;
			failed_total    <= fail_q;
			evicted_total   <= evc_q;
		end
	end

	assign out_valid = out_valid_q;

	rbe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	rbe_ram #(.WIDTH(ST_W), .DEPTH(ENTRIES)) u_state_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (scan_i_q[IDX_W-1:0]),
		.rdata (st_rdata)
	);

	rbe_ram #(.WIDTH(SUM_W), .DEPTH(ENTRIES)) u_size_ram (
		.clk   (clk),
		.we    (sz_we),
		.waddr (idx_q),
		.wdata (bytes_q[SUM_W-1:0]),
		.raddr (scan_i_q[IDX_W-1:0]),
		.rdata (sz_rdata)
	);

endmodule
`default_nettype wire

FILE: sv/rbe_ram.sv
`default_nettype none
module rbe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: sv/rbe_div.sv
`default_nettype none
module rbe_div import rbe_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	localparam int STEP_W = $clog2(WIDE_W) + 1;

	logic [STEP_W-1:0] step_q;
	logic [WIDE_W-1:0] dvd_q;
	logic [WIDE_W-1:0] quo_q;
	logic [TGT_W-1:0]  rem_q;
	logic [TGT_W-1:0]  dvs_q;
	logic [TGT_W:0]    trial;
	logic              take;

	assign trial = {rem_q, dvd_q[WIDE_W-1]};
	assign take  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (req.start) begin
			step_q <= STEP_W'(WIDE_W);
		end else if (step_q != '0) begin
			step_q <= step_q - STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (step_q != '0) begin
			dvd_q <= {dvd_q[WIDE_W-2:0], 1'b0};
			quo_q <= {quo_q[WIDE_W-2:0], take};
			rem_q <= take ? TGT_W'(trial - {1'b0, dvs_q}) : TGT_W'(trial);
		end
	end

	assign rsp.busy      = step_q != '0;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule
`default_nettype wire

FILE: sv/rbe_checker.sv
`default_nettype none
module rbe_checker import rbe_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             out_valid,
	input wire logic             out_stall,
	input wire logic [2:0]       status,
	input wire logic [CNT_W-1:0] evicted_now,
	input wire logic [SUM_W-1:0] resident_total,
	input wire logic [SUM_W-1:0] resident_peak
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(resident_total))
		else $error("Result changed while its transfer was stalled.");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= 3'(STS_SWEEP))
		else $error("Result carries an undefined status.");

	a_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == 3'(STS_OUTSIDE) || status == 3'(STS_FAILED))
		|-> evicted_now == '0)
		else $error("A discarded or failed item evicted entries.");

	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> resident_peak >= resident_total)
		else $error("Resident peak is below the resident total.");

endmodule

bind resident_budget_evictor rbe_checker u_rbe_checker (.*);
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import rbe_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		bit        mode;
		bit [9:0]  thumb;
		bit [15:0] w;
		bit [15:0] h;
		bit        cached;
		bit [10:0] first;
		bit [10:0] last;
		bit [10:0] wend;
		bit [10:0] sel;
	} thumb_item_t;

	typedef struct {
		status_t   status;
		bit [10:0] evicted_now;
		bit [26:0] resident;
		bit [26:0] peak;
		bit [31:0] hits;
		bit [31:0] decoded;
		bit [31:0] discarded;
		bit [31:0] failed;
		bit [31:0] evicted;
	} budget_result_t;

	class budget_scoreboard;
		longint unsigned target;
		longint unsigned count;
		bit              carousel;
		entry_state_t    state [ENTRIES];
		longint unsigned size [ENTRIES];
		longint unsigned sum;
		longint unsigned peak;
		bit [31:0]       hits, decoded, discarded, failed, evicted;
		budget_result_t  pending [$];
		int              errors;

		function void clear();
			target = 0;
			count = 0;
			carousel = 0;
			foreach (state[i]) begin
				state[i] = ES_UNLOADED;
				size[i] = 0;
			end
			sum = 0;
			peak = 0;
			hits = 0;
			decoded = 0;
			discarded = 0;
			failed = 0;
			evicted = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, bit [34:0] data);
			if (idx == REG_TARGET)
				target = data;
			else if (idx == REG_COUNT)
				count = data[10:0];
			else if (idx == REG_FLOW)
				carousel = data[0];
		endfunction

		function longint unsigned active();
			return count > ENTRIES ? ENTRIES : count;
		endfunction

		function longint unsigned lookahead(longint unsigned visible);
			longint unsigned slots, la;
			if (target == 0)
				return visible;
			slots = 64'd67108864 / target;
			if (slots <= visible)
				return 0;
			la = (slots - visible) / 2;
			return la < visible ? la : visible;
		endfunction

		function bit in_window(longint unsigned i, thumb_item_t it);
			longint unsigned n, visible, la, low, high, rest, span, start;
			n = active();
			visible = longint'(it.last) - longint'(it.first) + longint'(it.wend);
			if (visible == 0 || i >= n)
				return 0;
			la = lookahead(visible);
			if (!carousel) begin
				low = it.first > la ? it.first - la : 0;
				rest = n - it.last;
				high = it.last + (la < rest ? la : rest);
				return i >= low && i < high;
			end
			span = visible + la * 2;
			if (span >= n)
				return 1;
			start = (it.first + n - la) % n;
			return ((i + n - start) % n) < span;
		endfunction

		function bit in_visible(longint unsigned i, thumb_item_t it);
			return (i >= it.first && i < it.last) || i < it.wend;
		endfunction

		function void unload(int i);
			if (state[i] != ES_READY)
				return;
			sum = size[i] <= sum ? sum - size[i] : 0;
			state[i] = ES_UNLOADED;
			size[i] = 0;
			evicted++;
		endfunction

		function bit evict_first(thumb_item_t it, longint unsigned sel, bit vis);
			for (int i = 0; i < active(); i++) begin
				if (i == it.thumb || i == sel || state[i] != ES_READY ||
						in_visible(i, it) != vis)
					continue;
				unload(i);
				return 1;
			end
			return 0;
		endfunction

		function longint unsigned room();
			return sum >= 67108864 ? 0 : 67108864 - sum;
		endfunction

		function void note(thumb_item_t it);
			budget_result_t r;
			longint unsigned sel, bytes;
			bit [31:0] prior;
			prior = evicted;
			sel = it.sel >= ENTRIES ? 64'hFFFF_FFFF_FFFF_FFFF : it.sel;
			if (it.mode) begin
				for (int i = 0; i < active(); i++)
					if (!in_window(i, it))
						unload(i);
				r.status = STS_SWEEP;
			end else if (!in_window(it.thumb, it)) begin
				state[it.thumb] = ES_UNLOADED;
				discarded++;
				r.status = STS_OUTSIDE;
			end else begin
				bytes = longint'(it.w) * longint'(it.h) * 4;
				if (it.w == 0 || it.h == 0 || bytes > 67108864) begin
					state[it.thumb] = ES_FAILED;
					failed++;
					r.status = STS_FAILED;
				end else begin
					while (bytes > room()) begin
						if (evict_first(it, sel, 0))
							continue;
						if (!evict_first(it, sel, 1))
							break;
					end
					if (bytes > room()) begin
						state[it.thumb] = ES_UNLOADED;
						discarded++;
						r.status = STS_NO_ROOM;
					end else begin
						state[it.thumb] = ES_READY;
						size[it.thumb] = bytes;
						sum += bytes;
						if (sum > peak)
							peak = sum;
						if (it.cached)
							hits++;
						else
							decoded++;
						r.status = STS_STORED;
					end
				end
			end
			r.evicted_now = 11'(evicted - prior);
			r.resident = sum[26:0];
			r.peak = peak[26:0];
			r.hits = hits;
			r.decoded = decoded;
			r.discarded = discarded;
			r.failed = failed;
			r.evicted = evicted;
			pending.push_back(r);
		endfunction

		function void check(budget_result_t got);
			budget_result_t exp;
			if (pending.size() == 0) begin
				errors++;
				$error("result transfer with nothing expected");
				return;
			end
			exp = pending.pop_front();
			if (got.status != exp.status) begin
				errors++;
				$error("status: expected %0d, got %0d", exp.status, got.status);
			end
			if (got.evicted_now != exp.evicted_now) begin
				errors++;
				$error("evicted_now: expected %0d, got %0d", exp.evicted_now, got.evicted_now);
			end
			if (got.resident != exp.resident) begin
				errors++;
				$error("resident_total: expected %0d, got %0d", exp.resident, got.resident);
			end
			if (got.peak != exp.peak) begin
				errors++;
				$error("resident_peak: expected %0d, got %0d", exp.peak, got.peak);
			end
			if (got.hits != exp.hits) begin
				errors++;
				$error("hit_total: expected %0d, got %0d", exp.hits, got.hits);
			end
			if (got.decoded != exp.decoded) begin
				errors++;
				$error("decoded_total: expected %0d, got %0d", exp.decoded, got.decoded);
			end
			if (got.discarded != exp.discarded) begin
				errors++;
				$error("discarded_total: expected %0d, got %0d", exp.discarded,
					got.discarded);
			end
			if (got.failed != exp.failed) begin
				errors++;
				$error("failed_total: expected %0d, got %0d", exp.failed, got.failed);
			end
			if (got.evicted != exp.evicted) begin
				errors++;
				$error("evicted_total: expected %0d, got %0d", exp.evicted, got.evicted);
			end
		endfunction
	endclass

	logic              clk = 0;
	logic              arst_n = 0;
	logic              cfg_write = 0;
	logic [1:0]        cfg_index = REG_TARGET;
	logic [TGT_W-1:0]  cfg_data = 0;
	logic              in_valid = 0;
	logic              in_stall;
	logic              mode = 0;
	logic [IDX_W-1:0]  thumb_index = 0;
	logic [15:0]       pix_width = 0;
	logic [15:0]       pix_height = 0;
	logic              from_cache = 0;
	logic [CNT_W-1:0]  range_first = 0;
	logic [CNT_W-1:0]  range_end = 0;
	logic [CNT_W-1:0]  range_wrap_end = 0;
	logic [CNT_W-1:0]  selected_entry = 0;
	logic              out_valid;
	logic              out_stall = 0;
	logic [2:0]        status;
	logic [CNT_W-1:0]  evicted_now;
	logic [SUM_W-1:0]  resident_total;
	logic [SUM_W-1:0]  resident_peak;
	logic [CTR_W-1:0]  hit_total;
	logic [CTR_W-1:0]  decoded_total;
	logic [CTR_W-1:0]  discarded_total;
	logic [CTR_W-1:0]  failed_total;
	logic [CTR_W-1:0]  evicted_total;

	budget_scoreboard board = new();
	int  cycles = 0;
	int  burst_left = 0;
	int  hold_cycles = 0;
	int  stall_phase = 0;

	resident_budget_evictor dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// The receiver stalls in a slowly changing pattern, with a long hold-off when asked.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1;
		end else begin
			stall_phase <= (stall_phase + 1) % 97;
			out_stall <= stall_phase < 40 ? ($urandom_range(0, 2) == 0) : 1'b0;
		end
	end

	always @(posedge clk) begin
		thumb_item_t it;
		if (in_valid && !in_stall) begin
			it.mode = mode;
			it.thumb = thumb_index;
			it.w = pix_width;
			it.h = pix_height;
			it.cached = from_cache;
			it.first = range_first;
			it.last = range_end;
			it.wend = range_wrap_end;
			it.sel = selected_entry;
			board.note(it);
		end
	end

	always @(posedge clk) begin
		budget_result_t got;
		if (out_valid && !out_stall) begin
			got.status = status_t'(status);
			got.evicted_now = evicted_now;
			got.resident = resident_total;
			got.peak = resident_peak;
			got.hits = hit_total;
			got.decoded = decoded_total;
			got.discarded = discarded_total;
			got.failed = failed_total;
			got.evicted = evicted_total;
			board.check(got);
		end
	end

	task automatic send(bit m, int idx, int w, int h, bit c, int f, int e, int we, int s);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 8);
		end
		in_valid <= 1;
		mode <= m;
		thumb_index <= IDX_W'(idx);
		pix_width <= 16'(w);
		pix_height <= 16'(h);
		from_cache <= c;
		range_first <= CNT_W'(f);
		range_end <= CNT_W'(e);
		range_wrap_end <= CNT_W'(we);
		selected_entry <= CNT_W'(s);
		do @(posedge clk); while (in_stall);
		burst_left--;
	endtask

	task automatic send_random(int n);
		int idx, w, h, f, e, we, s, pick;
		idx = (n > 0 && $urandom_range(0, 9) != 0) ? $urandom_range(0, n - 1)
			: $urandom_range(0, 1023);
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			w = $urandom_range(0, 1) ? 0 : $urandom_range(0, 65535);
			h = w == 0 ? $urandom_range(0, 65535) : 0;
		end else if (pick < 13) begin
			w = $urandom_range(4097, 65535);
			h = $urandom_range(4097, 65535);
		end else if (pick < 55) begin
			w = $urandom_range(1024, 4096);
			h = $urandom_range(1024, 4096);
		end else begin
			w = $urandom_range(1, 512);
			h = $urandom_range(1, 512);
		end
		if ($urandom_range(0, 4) != 0) begin
			f = $urandom_range(0, n);
			e = $urandom_range(f, n);
			we = $urandom_range(0, 2) != 0 ? 0 : $urandom_range(0, f);
		end else begin
			f = $urandom_range(0, 1024);
			e = $urandom_range(0, 1024);
			we = $urandom_range(0, 1024);
		end
		s = $urandom_range(0, 1) ? 1024 : $urandom_range(0, n > 0 ? n : 1024);
		send($urandom_range(0, 9) == 0, idx, w, h, $urandom_range(0, 1), f, e, we, s);
	endtask

	task automatic drain();
		int waited;
		in_valid <= 0;
		burst_left = 0;
		waited = 0;
		while (board.pending.size() != 0 && waited < 500000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, bit [34:0] data);
		cfg_write <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		board.set_reg(idx, data);
		@(posedge clk);
		cfg_write <= 0;
	endtask

	task automatic run_phase(bit [34:0] tgt, int n, bit flow, int items, bit squeeze);
		drain();
		write_reg(REG_TARGET, tgt);
		write_reg(REG_COUNT, 35'(n));
		write_reg(REG_FLOW, 35'(flow));
		for (int k = 0; k < items; k++) begin
			if (squeeze && k == 5)
				hold_cycles = 4000;
			send_random(n);
		end
	endtask

	initial begin
		board.clear();
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		write_reg(REG_TARGET, 0);
		write_reg(REG_COUNT, 1024);
		write_reg(REG_FLOW, 0);
		send(1, 0, 0, 0, 0, 0, 0, 0, 1024);
		send(0, 5, 0, 100, 0, 0, 1024, 0, 1024);
		send(0, 6, 100, 0, 1, 0, 1024, 0, 1024);
		send(0, 7, 65535, 65535, 0, 0, 1024, 0, 1024);
		send(0, 8, 4096, 4096, 1, 0, 1024, 0, 1024);
		send(0, 9, 4096, 4096, 0, 0, 1024, 0, 9);
		send(0, 9, 100, 100, 1, 0, 1024, 0, 1024);
		send(0, 1023, 2048, 2048, 0, 0, 1024, 0, 1023);
		send(0, 10, 64, 64, 0, 0, 1024, 0, 10);
		send(0, 10, 64, 64, 1, 0, 1024, 0, 1024);
		send(0, 300, 10, 10, 0, 500, 600, 0, 1024);
		send(0, 20, 10, 10, 0, 500, 100, 0, 1024);
		send(0, 3, 4096, 4095, 0, 1000, 1024, 16, 1024);
		send(0, 1020, 3000, 3000, 1, 1000, 1024, 16, 3);
		send(0, 700, 1, 1, 0, 0, 1024, 1024, 1024);
		send(1, 0, 0, 0, 0, 1000, 1024, 16, 1024);
		send(0, 10, 1, 1, 0, 0, 0, 0, 1024);
		send(1, 0, 0, 0, 0, 0, 1024, 0, 1024);
		for (int k = 0; k < 40; k++)
			send_random(1024);
		run_phase(35'd4194304, 32, 1, 80, 1);
		run_phase(35'h4_0000_0000, 1, 0, 20, 0);
		run_phase(35'd1, 1024, 1, 35, 0);
		run_phase(35'd67108864, 200, 0, 60, 0);
		run_phase(35'd0, 0, 1, 10, 0);
		run_phase(35'd16777216, 24, 0, 25, 0);
		drain();
		repeat (200) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
